@@ hw/rtl/text_indent_level_tracker_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the indentation level tracker
// Clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_INDENT_LEVEL_TRACKER_MACROS_SVH
`define TEXT_INDENT_LEVEL_TRACKER_MACROS_SVH

// Property must hold at every clock edge outside reset
`define TILT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define TILT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/tilt_pkg.sv @@
// ---------------------------------------------------------------------------
// tilt_pkg
// Shared constants, byte codes and control structs of the indentation
// level tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package tilt_pkg;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 24;
	localparam int LEVEL_W = 3;
	localparam int TAB_W   = 5;
	localparam int PHASE_W = 4;

	// Parameter defaults
	localparam int STACK_DEPTH_DEF = 8;
	localparam int INDENT_BITS_DEF = 10;

	// Tab width register
	localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(4);
	localparam logic [TAB_W-1:0] TAB_MAX   = TAB_W'(16);

	// Byte codes
	localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_SP  = 8'h20;
	localparam logic [BYTE_W-1:0] BYTE_TAB = 8'h09;

	// Indent measurement commands
	typedef struct packed {
		logic clear;
		logic add_space;
		logic add_tab;
	} col_ctrl_t;

	// Stack commands and status
	typedef struct packed {
		logic clear;
		logic step;
	} stk_ctrl_t;

	typedef struct packed {
		logic pop_more;
		logic push_ok;
	} stk_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/tilt_ifs.sv @@
// ---------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for text bytes in and line results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface tilt_in_if import tilt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  text_byte;
	logic               end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tilt_out_if import tilt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COUNT_W-1:0]  line_number;
	logic [LEVEL_W-1:0]  level;
	logic [COUNT_W-1:0]  ordinal;
	logic [LEVEL_W-1:0]  max_level;

	modport source (output valid, output line_number, output level, output ordinal,
		output max_level, input ready);
	modport sink   (input valid, input line_number, input level, input ordinal,
		input max_level, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/text_indent_level_tracker.sv @@
// ---------------------------------------------------------------------------
// text_indent_level_tracker
// Reports the indentation nesting level of every non-blank line of a
// byte stream.
// ---------------------------------------------------------------------------
// Bytes are taken one per transaction. A space, tab or ordinary content
// byte is taken in S_IDLE. A line break (LF or CR) moves to S_CLOSE,
// which closes the line and loads the result register. The LF that
// completes a CR LF pair is dropped in S_IDLE. The first content byte
// of a line enters S_SETTLE, where wider stack entries are popped:
// the stack has a single comparator that inspects one entry per cycle.
// A byte marked end_of_text leads to a close that also clears the stack
// and counters. Closing a non-blank line waits while an earlier result
// is still held in the output register and not taken.
// ---------------------------------------------------------------------------
`default_nettype none
`include "text_indent_level_tracker_macros.svh"

module text_indent_level_tracker import tilt_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int INDENT_BITS = INDENT_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [TAB_W-1:0]  cfg_wdata,
	tilt_in_if.sink                in_ch,
	tilt_out_if.source             out_ch
);

	localparam int HT_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SETTLE,
		S_CLOSE
	} state_t;

	state_t                 state_q;
	logic [TAB_W-1:0]       tab_width_q;
	logic                   acr_q;
	logic                   eot_q;
	logic                   close_q;
	logic                   in_indent_q;
	logic                   has_content_q;
	logic                   line_open_q;
	logic [COUNT_W-1:0]     line_count_q;
	logic [COUNT_W-1:0]     entry_count_q;
	logic [LEVEL_W-1:0]     deepest_q;
	logic [LEVEL_W-1:0]     pending_q;
	logic                   out_valid_q;
	logic [COUNT_W-1:0]     out_line_q;
	logic [LEVEL_W-1:0]     out_level_q;
	logic [COUNT_W-1:0]     out_ordinal_q;
	logic [LEVEL_W-1:0]     out_max_q;

	logic                   accept;
	logic                   is_lf, is_cr, is_sp, is_tab;
	logic                   swallow, brk, plain, content, first_content;
	logic                   do_close, emit, slot_free, close_go;
	logic [COUNT_W-1:0]     line_next, entry_next;
	logic [LEVEL_W-1:0]     max_next;
	col_ctrl_t              col_ctrl;
	stk_ctrl_t              stk_ctrl;
	stk_stat_t              stk_stat;
	logic [INDENT_BITS-1:0] columns;
	logic [HT_W-1:0]        stk_height;
	logic [LEVEL_W-1:0]     settle_level;

	// Tab width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_width_q <= TAB_RESET;
		end else if (cfg_we) begin
			tab_width_q <= cfg_wdata;
		end
	end

	// Classify the incoming byte
	always_comb begin
		accept        = in_ch.valid && in_ch.ready;
		is_lf         = (in_ch.text_byte == BYTE_LF);
		is_cr         = (in_ch.text_byte == BYTE_CR);
		is_sp         = (in_ch.text_byte == BYTE_SP);
		is_tab        = (in_ch.text_byte == BYTE_TAB);
		swallow       = acr_q && is_lf;
		brk           = !swallow && (is_lf || is_cr);
		plain         = !swallow && !is_lf && !is_cr;
		content       = plain && !is_sp && !is_tab;
		first_content = content && in_indent_q;
	end

	// Line close and result values
	always_comb begin
		do_close   = close_q || line_open_q;
		emit       = do_close && has_content_q;
		slot_free  = !out_valid_q || out_ch.ready;
		close_go   = (state_q == S_CLOSE) && (!emit || slot_free);
		line_next  = (line_count_q != '1) ? (line_count_q + 1'b1) : line_count_q;
		entry_next = (entry_count_q != '1) ? (entry_count_q + 1'b1) : entry_count_q;
		max_next   = (pending_q > deepest_q) ? pending_q : deepest_q;
	end

	// Commands to the indent counter and the stack
	always_comb begin
		col_ctrl.clear     = close_go;
		col_ctrl.add_space = accept && plain && is_sp && in_indent_q;
		col_ctrl.add_tab   = accept && plain && is_tab && in_indent_q;
		stk_ctrl.clear     = close_go && eot_q;
		stk_ctrl.step      = (state_q == S_SETTLE);
	end

	tilt_column #(
		.INDENT_BITS (INDENT_BITS)
	) u_column (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (col_ctrl),
		.tab_width (tab_width_q),
		.columns   (columns)
	);

	tilt_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.INDENT_BITS (INDENT_BITS)
	) u_stack (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (stk_ctrl),
		.indent       (columns),
		.stat         (stk_stat),
		.height       (stk_height),
		.settle_level (settle_level)
	);

	// Sequencer, line state, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			acr_q         <= 1'b0;
			eot_q         <= 1'b0;
			close_q       <= 1'b0;
			in_indent_q   <= 1'b1;
			has_content_q <= 1'b0;
			line_open_q   <= 1'b0;
			line_count_q  <= '0;
			entry_count_q <= '0;
			deepest_q     <= '0;
			pending_q     <= '0;
			out_valid_q   <= 1'b0;
			out_line_q    <= '0;
			out_level_q   <= '0;
			out_ordinal_q <= '0;
			out_max_q     <= '0;
		end else begin
			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ch.ready && !(close_go && emit)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						acr_q   <= brk && is_cr;
						eot_q   <= in_ch.end_of_text;
						close_q <= brk;
						if (plain) begin
							line_open_q <= 1'b1;
						end
						if (content) begin
							has_content_q <= 1'b1;
						end
						if (first_content) begin
							in_indent_q <= 1'b0;
							state_q     <= S_SETTLE;
						end else if (brk || in_ch.end_of_text) begin
							state_q <= S_CLOSE;
						end
					end
				end
				S_SETTLE: begin
					// Hold here while the stack pops wider entries
					if (!stk_stat.pop_more) begin
						pending_q <= settle_level;
						state_q   <= eot_q ? S_CLOSE : S_IDLE;
					end
				end
				S_CLOSE: begin
					if (close_go) begin
						if (emit) begin
							out_valid_q   <= 1'b1;
							out_line_q    <= line_next;
							out_level_q   <= pending_q;
							out_ordinal_q <= entry_next;
							out_max_q     <= max_next;
						end
						in_indent_q   <= 1'b1;
						has_content_q <= 1'b0;
						line_open_q   <= 1'b0;
						close_q       <= 1'b0;
						// End of text: start a fresh text
						if (eot_q) begin
							line_count_q  <= '0;
							entry_count_q <= '0;
							deepest_q     <= '0;
							pending_q     <= '0;
							acr_q         <= 1'b0;
							eot_q         <= 1'b0;
						end else begin
							if (do_close) begin
								line_count_q <= line_next;
							end
							if (emit) begin
								entry_count_q <= entry_next;
								deepest_q     <= max_next;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Channel outputs
	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.line_number = out_line_q;
	assign out_ch.level       = out_level_q;
	assign out_ch.ordinal     = out_ordinal_q;
	assign out_ch.max_level   = out_max_q;

	// Checks
	`TILT_ASSERT(a_height_bound, (stk_height <= HT_W'(STACK_DEPTH)), "stack height over depth")
	`TILT_ASSERT(a_result_from_close, $rose(out_ch.valid) |-> $past(state_q == S_CLOSE), "result loaded outside close")
	`TILT_ASSERT(a_max_covers_level, out_ch.valid |-> (out_ch.max_level >= out_ch.level), "max level below level")
	`TILT_ASSERT(a_text_cleared, (close_go && eot_q) |=> (line_count_q == '0 && stk_height == '0), "text state not cleared")
	`TILT_NEVER(a_settle_while_open_result, (state_q == S_SETTLE) && close_q, "line break pending during settle")

endmodule

`default_nettype wire

@@ hw/rtl/tilt_column.sv @@
// ---------------------------------------------------------------------------
// tilt_column
// Measures the indent of the current line: spaces add one column, tabs
// jump to the next tab stop tracked by a phase counter. Saturates.
// ---------------------------------------------------------------------------
`default_nettype none

module tilt_column import tilt_pkg::*; #(
	parameter int INDENT_BITS = INDENT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire col_ctrl_t              ctrl,
	input  wire logic [TAB_W-1:0]       tab_width,
	output      logic [INDENT_BITS-1:0] columns
);

	localparam int SUM_W = INDENT_BITS + 2;
	localparam logic [INDENT_BITS-1:0] INDENT_MAX = '1;

	logic [INDENT_BITS-1:0] cols_q;
	logic [PHASE_W-1:0]     phase_q;
	logic [TAB_W-1:0]       tw_eff;
	logic [TAB_W-1:0]       phase_inc;
	logic [TAB_W-1:0]       step;
	logic [SUM_W-1:0]       tab_sum;

	// Clamp the tab width into 1..16
	always_comb begin
		if (tab_width == '0) begin
			tw_eff = TAB_W'(1);
		end else if (tab_width > TAB_MAX) begin
			tw_eff = TAB_MAX;
		end else begin
			tw_eff = tab_width;
		end
	end

	// Distance to the next tab stop and the saturating sum
	always_comb begin
		phase_inc = TAB_W'(phase_q) + TAB_W'(1);
		step      = (TAB_W'(phase_q) < tw_eff) ? (tw_eff - TAB_W'(phase_q)) : tw_eff;
		tab_sum   = SUM_W'(cols_q) + SUM_W'(step);
	end

	// Advance the column count and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= '0;
			phase_q <= '0;
		end else if (ctrl.clear) begin
			cols_q  <= '0;
			phase_q <= '0;
		end else if (ctrl.add_space) begin
			if (cols_q != INDENT_MAX) begin
				cols_q <= cols_q + 1'b1;
			end
			phase_q <= (phase_inc >= tw_eff) ? '0 : phase_inc[PHASE_W-1:0];
		end else if (ctrl.add_tab) begin
			cols_q  <= (tab_sum > SUM_W'(INDENT_MAX)) ? INDENT_MAX
				: tab_sum[INDENT_BITS-1:0];
			phase_q <= '0;
		end
	end

	assign columns = cols_q;

endmodule

`default_nettype wire

@@ hw/rtl/tilt_stack.sv @@
// ---------------------------------------------------------------------------
// tilt_stack
// Indent stack with one shared comparator. Each settle step compares the
// top entry with the indent: pop while wider, then push a wider indent if not full.
// ---------------------------------------------------------------------------
`default_nettype none

module tilt_stack import tilt_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int INDENT_BITS = INDENT_BITS_DEF,
	localparam int HT_W  = $clog2(STACK_DEPTH + 1),
	localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire stk_ctrl_t              ctrl,
	input  wire logic [INDENT_BITS-1:0] indent,
	output      stk_stat_t              stat,
	output      logic [HT_W-1:0]        height,
	output      logic [LEVEL_W-1:0]     settle_level
);

	logic [INDENT_BITS-1:0] stack_q [STACK_DEPTH];
	logic [HT_W-1:0]        height_q;
	logic [HT_W-1:0]        top_pos;
	logic [HT_W-1:0]        height_after;
	logic [INDENT_BITS-1:0] top;
	logic                   empty;
	logic                   full;

	// Shared compare of the top entry against the indent
	always_comb begin
		empty         = (height_q == '0);
		full          = (height_q == HT_W'(STACK_DEPTH));
		top_pos       = height_q - 1'b1;
		top           = stack_q[top_pos[PTR_W-1:0]];
		stat.pop_more = !empty && (top > indent);
		stat.push_ok  = !full && (empty || (top < indent));
		height_after  = stat.push_ok ? (height_q + 1'b1) : height_q;
		settle_level  = (height_after == '0) ? '0
			: LEVEL_W'(32'(height_after) - 32'd1);
	end

	// Pop one entry per step, then push when settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= '0;
		end else if (ctrl.clear) begin
			height_q <= '0;
		end else if (ctrl.step) begin
			if (stat.pop_more) begin
				height_q <= height_q - 1'b1;
			end else if (stat.push_ok) begin
				height_q <= height_q + 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (ctrl.step && !ctrl.clear && !stat.pop_more && stat.push_ok) begin
			stack_q[height_q[PTR_W-1:0]] <= indent;
		end
	end

	assign height = height_q;

endmodule

`default_nettype wire

@@ bench/text_indent_level_tracker_tb.sv @@
// ---------------------------------------------------------------------------
// text_indent_level_tracker_tb
// Streams text bytes into the indentation level tracker under random
// stalls on both channels and a set of tab widths. Predicts each line
// result independently and checks every result in order, field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module text_indent_level_tracker_tb;
	import tilt_pkg::*;

	localparam int STACK_DEPTH          = STACK_DEPTH_DEF;
	localparam int INDENT_BITS          = INDENT_BITS_DEF;
	localparam int unsigned INDENT_MAX  = (1 << INDENT_BITS) - 1;
	localparam int unsigned COUNT_MAX   = 24'hFFFFFF;
	localparam int unsigned LEVEL_MASK  = 7;
	localparam int CYCLE_LIMIT          = 300000;
	localparam int HOLD_CYCLES          = 400;
	localparam int SETTLE_CYCLES        = 24;
	localparam int PHASE_ITEMS          = 130;
	localparam int PLAN_LEN             = 11;
	localparam logic [TAB_W-1:0] TAB_PLAN [PLAN_LEN] = '{
		5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd2, 5'd8, 5'd3, 5'd5, 5'd10, 5'd4
	};

	typedef struct packed {
		logic [COUNT_W-1:0] line_number;
		logic [LEVEL_W-1:0] level;
		logic [COUNT_W-1:0] ordinal;
		logic [LEVEL_W-1:0] max_level;
	} line_result_t;

	// Line level predictor and store of expected line results
	class level_scoreboard;
		logic [TAB_W-1:0] tab_reg;
		int unsigned      widths [STACK_DEPTH];
		int unsigned      height, columns, phase;
		int unsigned      line_count, entry_count, deepest, pending;
		bit               in_indent, has_content, line_open, after_cr;
		line_result_t     expected_lines [$];
		int unsigned      mismatches, checked, full_skips, saturations, crlf_pairs;

		function new();
			tab_reg = TAB_RESET;
			clear_text();
		endfunction

		function void clear_text();
			height = 0;
			columns = 0;
			phase = 0;
			in_indent = 1;
			has_content = 0;
			line_open = 0;
			after_cr = 0;
			line_count = 0;
			entry_count = 0;
			deepest = 0;
			pending = 0;
		endfunction

		function int unsigned tab_span();
			if (tab_reg == 0) return 1;
			if (tab_reg > TAB_MAX) return TAB_MAX;
			return tab_reg;
		endfunction

		// Count the line; queue a result only if it held content
		function void close_line();
			line_result_t r;
			if (line_count < COUNT_MAX) line_count++;
			if (has_content) begin
				if (entry_count < COUNT_MAX) entry_count++;
				if (pending > deepest) deepest = pending;
				r.line_number = line_count[COUNT_W-1:0];
				r.level       = pending[LEVEL_W-1:0];
				r.ordinal     = entry_count[COUNT_W-1:0];
				r.max_level   = deepest[LEVEL_W-1:0];
				expected_lines.push_back(r);
			end
			columns = 0;
			phase = 0;
			in_indent = 1;
			has_content = 0;
			line_open = 0;
		endfunction

		// Pop wider entries, push a wider indent unless the stack is full
		function void settle_indent();
			while (height > 0 && widths[height-1] > columns) height--;
			if (height == 0 || widths[height-1] < columns) begin
				if (height < STACK_DEPTH) begin
					widths[height] = columns;
					height++;
				end else begin
					full_skips++;
				end
			end
			pending = (height > 0) ? ((height - 1) & LEVEL_MASK) : 0;
		endfunction

		function void add_space();
			int unsigned span;
			span = tab_span();
			if (columns < INDENT_MAX) columns++;
			else saturations++;
			phase = (phase + 1 >= span) ? 0 : phase + 1;
		endfunction

		// A stale phase at or past the width advances by the full width
		function void add_tab();
			int unsigned span, stride;
			span = tab_span();
			stride = (phase < span) ? span - phase : span;
			if (columns + stride > INDENT_MAX) begin
				columns = INDENT_MAX;
				saturations++;
			end else begin
				columns += stride;
			end
			phase = 0;
		endfunction

		// Advance the prediction by one accepted input transaction
		function void take_byte(logic [BYTE_W-1:0] b, logic eot);
			if (after_cr && b == BYTE_LF) begin
				after_cr = 0;
				crlf_pairs++;
			end else begin
				after_cr = 0;
				if (b == BYTE_LF) begin
					close_line();
				end else if (b == BYTE_CR) begin
					close_line();
					after_cr = 1;
				end else begin
					line_open = 1;
					if (b == BYTE_SP) begin
						if (in_indent) add_space();
					end else if (b == BYTE_TAB) begin
						if (in_indent) add_tab();
					end else begin
						if (in_indent) begin
							in_indent = 0;
							settle_indent();
						end
						has_content = 1;
					end
				end
			end
			if (eot) begin
				if (line_open) close_line();
				clear_text();
			end
		endfunction

		// Compare one output transaction with the oldest expected line
		function void check_line(line_result_t got);
			line_result_t want;
			string        bad;
			checked++;
			if (expected_lines.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result line %0d level %0d ordinal %0d max %0d",
						got.line_number, got.level, got.ordinal, got.max_level);
				return;
			end
			want = expected_lines.pop_front();
			bad = "";
			if (got.line_number !== want.line_number) bad = {bad, " line_number"};
			if (got.level !== want.level) bad = {bad, " level"};
			if (got.ordinal !== want.ordinal) bad = {bad, " ordinal"};
			if (got.max_level !== want.max_level) bad = {bad, " max_level"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: mismatch in%s: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						bad, want.line_number, want.level, want.ordinal, want.max_level,
						got.line_number, got.level, got.ordinal, got.max_level);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [TAB_W-1:0] cfg_wdata;

	tilt_in_if  in_ch ();
	tilt_out_if out_ch ();

	text_indent_level_tracker #(
		.STACK_DEPTH (STACK_DEPTH),
		.INDENT_BITS (INDENT_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	level_scoreboard sb = new();

	int unsigned items_sent  = 0;
	int unsigned phase_items = 0;
	int unsigned phase_no    = 0;
	int unsigned cycle_count = 0;
	int unsigned text_depth  = 0;
	int unsigned indent_unit = 2;
	bit          steady_flow = 0;
	bit          hold_done   = 0;

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one byte and hold it until the transaction completes
	task automatic send_item(input logic [BYTE_W-1:0] b, input logic eot);
		int unsigned gap;
		gap = steady_flow ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.text_byte   <= b;
		in_ch.end_of_text <= eot;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.take_byte(b, eot);
		items_sent++;
		phase_items++;
	endtask

	// Write the tab width once every expected line has drained
	task automatic set_tab_width(input logic [TAB_W-1:0] v);
		in_ch.valid <= 1'b0;
		while (sb.expected_lines.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		sb.tab_reg = v;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] pick_glyph();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(0, 255));
		while (b == BYTE_LF || b == BYTE_CR || b == BYTE_SP || b == BYTE_TAB);
		return b;
	endfunction

	// One structured line: indent by nesting depth, content, line break
	task automatic send_text_line();
		int unsigned n_glyphs, ending, brk;
		logic [BYTE_W-1:0] b;
		case ($urandom_range(0, 5))
			0:       text_depth = $urandom_range(0, text_depth);
			1, 2:    ;
			3, 4:    if (text_depth < 11) text_depth++;
			default: if (text_depth > 0) text_depth--;
		endcase
		if (sb.tab_span() >= 8 && $urandom_range(0, 59) == 0) begin
			repeat (INDENT_MAX / sb.tab_span() + 2) send_item(BYTE_TAB, 1'b0);
		end else begin
			for (int i = 0; i < text_depth; i++) begin
				if ($urandom_range(0, 3) == 0) send_item(BYTE_TAB, 1'b0);
				else repeat (indent_unit) send_item(BYTE_SP, 1'b0);
			end
		end
		// Leave about one line in ten blank
		if ($urandom_range(0, 9) != 0) begin
			send_item(pick_glyph(), 1'b0);
			n_glyphs = $urandom_range(0, 5);
			repeat (n_glyphs) begin
				case ($urandom_range(0, 7))
					0:       b = BYTE_SP;
					1:       b = BYTE_TAB;
					default: b = pick_glyph();
				endcase
				send_item(b, 1'b0);
			end
		end
		ending = $urandom_range(0, 19);
		if (ending == 0) begin
			send_item(pick_glyph(), 1'b1);
		end else begin
			brk = $urandom_range(0, 2);
			if (brk == 0) begin
				send_item(BYTE_LF, ending == 1);
			end else if (brk == 1) begin
				send_item(BYTE_CR, ending == 1);
			end else begin
				send_item(BYTE_CR, 1'b0);
				send_item(BYTE_LF, ending == 1);
			end
		end
		if (ending <= 1) begin
			text_depth  = 0;
			indent_unit = $urandom_range(1, 4);
		end
	endtask

	// Mostly structured lines, the rest short bursts of raw bytes
	task automatic send_random(input int unsigned n_items);
		int unsigned start;
		logic [BYTE_W-1:0] b;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(0, 9) != 0) begin
				send_text_line();
			end else begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 5))
						0:       b = BYTE_LF;
						1:       b = BYTE_CR;
						2:       b = BYTE_SP;
						3:       b = BYTE_TAB;
						default: b = BYTE_W'($urandom_range(0, 255));
					endcase
					send_item(b, $urandom_range(0, 29) == 0);
				end
			end
		end
	endtask

	// Sink side: random stalls, one long hold-off early in the random part
	initial begin : result_sink
		int unsigned  gap;
		line_result_t got;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!hold_done && phase_no >= 1 && phase_items >= 10) begin
				hold_done = 1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = steady_flow ? 0 : $urandom_range(0, 16);
				if (gap != 0) begin
					out_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			got.line_number = out_ch.line_number;
			got.level       = out_ch.level;
			got.ordinal     = out_ch.ordinal;
			got.max_level   = out_ch.max_level;
			sb.check_line(got);
		end
	end

	initial begin : text_source
		logic [BYTE_W:0] opening [$];
		in_ch.valid       <= 1'b0;
		in_ch.text_byte   <= '0;
		in_ch.end_of_text <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= TAB_RESET;
		arst_n            <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Byte extremes, CR LF pair, blank line, pops and pushes, end of text
		opening = '{
			{1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, BYTE_LF},
			{1'b0, BYTE_SP}, {1'b0, BYTE_SP}, {1'b0, 8'h78}, {1'b0, BYTE_SP},
			{1'b0, BYTE_TAB}, {1'b0, BYTE_CR}, {1'b0, BYTE_LF},
			{1'b0, BYTE_TAB}, {1'b0, BYTE_SP}, {1'b0, BYTE_CR},
			{1'b0, BYTE_TAB}, {1'b0, 8'h79}, {1'b0, BYTE_LF},
			{1'b0, BYTE_SP}, {1'b0, 8'h7A}, {1'b0, BYTE_LF},
			{1'b1, 8'h71}, {1'b1, BYTE_SP},
			{1'b0, BYTE_SP}, {1'b0, BYTE_SP}, {1'b0, BYTE_SP}
		};
		foreach (opening[i]) send_item(opening[i][BYTE_W-1:0], opening[i][BYTE_W]);

		// Narrow the width mid-line so the tab phase is left stale
		set_tab_width(5'd2);
		send_item(BYTE_TAB, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(BYTE_LF, 1'b0);
		repeat (3) send_item(BYTE_SP, 1'b0);
		set_tab_width(5'd1);
		send_item(BYTE_SP, 1'b0);
		send_item(BYTE_TAB, 1'b0);
		send_item(8'h62, 1'b1);

		// Random text under each tab width in turn
		for (int k = 0; k < PLAN_LEN; k++) begin
			set_tab_width(TAB_PLAN[k]);
			steady_flow = (k % 3 == 1);
			phase_items = 0;
			phase_no    = k + 1;
			send_random(PHASE_ITEMS);
		end

		// Drain and finish
		in_ch.valid <= 1'b0;
		while (sb.expected_lines.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d bytes and %0d line results over %0d tab widths",
			items_sent, sb.checked, PLAN_LEN + 2);
		$display("with %0d CR LF pairs, %0d full-stack skips and %0d indent saturations.",
			sb.crlf_pairs, sb.full_skips, sb.saturations);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
